[hdl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Shared codes and the command and status bundles between the allocator's
// controller and datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Request opcodes; the fourth code is a no-op that is reported as ignored.
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_FORMAT = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_IGNORED = 2'd2;

    // Register word index of first_data_block.
    localparam logic REG_FIRST_DATA_BLOCK = 1'b0;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_DECODE   = 8'b0000_0100,
        S_FORMAT   = 8'b0000_1000,
        S_SCAN     = 8'b0001_0000,
        S_SETBIT   = 8'b0010_0000,
        S_FREE_CHK = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } bba_state_t;

    typedef struct packed {
        logic       op_start;
        logic       sweep_wr;
        logic       sweep_zero;
        logic       rd;
        logic       commit_alloc;
        logic       commit_free;
        logic       count_load;
        logic       res_load;
        logic [1:0] res_status;
        logic       out_load;
    } bba_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       last_addr;
        logic       count_zero;
        logic       start_bad;
        logic       idx_bad;
        logic       rd_vld;
        logic       hit;
        logic       rd_last;
        logic       scan_end;
        logic       bit_used;
        logic       out_busy;
    } bba_stat_t;

endpackage

[hdl/block_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit block allocator over a used/free bitmap with a free-block count.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (opcode, block_index) and each one gives
// exactly one beat on the out channel (status, granted_block, blocks_free).
// A beat moves when valid is high and stall is low. first_data_block is set
// through the APB port at byte address 0 and takes effect at the next request;
// it does not reformat the map.
// The bitmap is held as W = ceil(NUM_BLOCKS / 64) words in one memory with
// one read and one write port. One request is in work at a time:
//   allocate: reads the words from the one holding first_data_block on,
//             one word a cycle, until a free bit is found or the map ends;
//   free:     reads the word of the block and clears its bit if it is set;
//   format:   writes every word of the map, one word written a cycle.
// After reset the block sweeps the memory to zero and holds in_stall high
// meanwhile; APB writes are taken.
// A finished beat waits in the output register while out_stall is high; the
// next request may be taken meanwhile, and its result waits for the register.
// ----------------------------------------------------------------------------
module block_bitmap_allocator
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [11:0] block_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [11:0] granted_block,
    output logic [12:0] blocks_free
);

    logic [11:0] fdb_reg;
    bba_cmd_t    cmd;
    bba_stat_t   stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fdb_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_FIRST_DATA_BLOCK))
        begin
            fdb_reg <= pwdata[11:0];
        end
    end

    assign prdata = (paddr[2] == REG_FIRST_DATA_BLOCK) ? {20'd0, fdb_reg} : 32'd0;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .first_data_block (fdb_reg),
        .opcode           (opcode),
        .block_index      (block_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .granted_block    (granted_block),
        .blocks_free      (blocks_free)
    );

    // A request is worked on alone: the port is busy right after an accept.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("request accepted while another is in work");

    // Only a successful allocation reports a block.
    a_grant_only_on_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STAT_DONE)) |-> (granted_block == 12'd0)
    ) else $error("granted block reported on a failed request");

    a_status_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == STAT_DONE) || (status == STAT_FULL) ||
                       (status == STAT_IGNORED))
    ) else $error("undefined status code");

    // A fresh result is loaded only into an empty or draining output register.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) &&
                                      $stable(granted_block))
    ) else $error("pending result overwritten");

endmodule

[hdl/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: runs the clearing pass after reset and steps
// each request through decode, bitmap sweep, scan or word read, commit and response.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  bba_stat_t stat,
    output bba_cmd_t  cmd
);

    bba_state_t state_reg;
    bba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep_wr   = 1'b1;
                cmd.sweep_zero = 1'b1;
                if (stat.last_addr)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op_start = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.opcode)
                    OP_ALLOC:
                    begin
                        if (stat.count_zero || stat.start_bad)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STAT_FULL;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_FREE:
                    begin
                        if (stat.idx_bad)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STAT_IGNORED;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            cmd.rd     = 1'b1;
                            state_next = S_FREE_CHK;
                        end
                    end
                    OP_FORMAT:
                    begin
                        state_next = S_FORMAT;
                    end
                    default:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STAT_IGNORED;
                        state_next     = S_RESP;
                    end
                endcase
            end
            S_FORMAT:
            begin
                cmd.sweep_wr = 1'b1;
                if (stat.last_addr)
                begin
                    cmd.count_load = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_DONE;
                    state_next     = S_RESP;
                end
            end
            S_SCAN:
            begin
                // Reads stream one word a cycle; the word read last cycle is
                // examined while the next one is fetched.
                if (stat.rd_vld && stat.hit)
                begin
                    state_next = S_SETBIT;
                end
                else if (stat.rd_vld && stat.rd_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STAT_FULL;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.rd = !stat.scan_end;
                end
            end
            S_SETBIT:
            begin
                cmd.commit_alloc = 1'b1;
                cmd.res_load     = 1'b1;
                cmd.res_status   = STAT_DONE;
                state_next       = S_RESP;
            end
            S_FREE_CHK:
            begin
                cmd.res_load = 1'b1;
                if (stat.bit_used)
                begin
                    cmd.commit_free = 1'b1;
                    cmd.res_status  = STAT_DONE;
                end
                else
                begin
                    cmd.res_status = STAT_IGNORED;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

[hdl/bba_dp.sv]
// ----------------------------------------------------------------------------
// bba_dp
// Datapath of the allocator: the bitmap memory of 64-bit words, the free
// counter, the lowest-free-bit search on the word just read, and the result
// and output registers.
// ----------------------------------------------------------------------------
module bba_dp
    import bba_pkg::*;
#(
    parameter int NUM_BLOCKS = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  bba_cmd_t    cmd,
    output bba_stat_t   stat,
    input  logic [11:0] first_data_block,
    input  logic [1:0]  opcode,
    input  logic [11:0] block_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [11:0] granted_block,
    output logic [12:0] blocks_free
);

    localparam int WORDS = (NUM_BLOCKS + 63) / 64;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LW    = (CNT_W > 13) ? CNT_W : 13;
    localparam int TAIL  = NUM_BLOCKS % 64;

    localparam logic [LW-1:0]   N_L     = LW'(NUM_BLOCKS);
    localparam logic [WA_W-1:0] LAST_A  = WA_W'(WORDS - 1);
    localparam logic [63:0]     HI_MASK = (TAIL == 0) ? 64'd0 :
                                          ~((64'd1 << TAIL) - 64'd1);

    logic [63:0] mem [WORDS];

    logic [1:0]       op_reg;
    logic [11:0]      idx_reg;
    logic [WA_W-1:0]  addr_reg;
    logic [WA_W-1:0]  rd_addr_reg;
    logic [63:0]      rd_data_reg;
    logic             rd_vld_reg;
    logic             scan_end_reg;
    logic [63:0]      oh_reg;
    logic [5:0]       pos_reg;
    logic [CNT_W-1:0] free_total_reg;
    logic [1:0]       res_status_reg;
    logic [11:0]      res_grant_reg;
    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [11:0]      out_grant_reg;
    logic [12:0]      out_free_reg;

    logic [LW-1:0]   fdb_l;
    logic [LW-1:0]   idx_l;
    logic [LW-1:0]   start_l;
    logic [LW-1:0]   base_l;
    logic [LW-1:0]   diff_l;
    logic [63:0]     fmt_word;
    logic [63:0]     lo_mask;
    logic [63:0]     hi_mask;
    logic [63:0]     free_vec;
    logic [63:0]     onehot;
    logic [5:0]      pos;
    logic [LW-1:0]   grant_l;
    logic            wr_en;
    logic [WA_W-1:0] wr_addr;
    logic [63:0]     wr_data;
    logic [WA_W-1:0] start_word;

    assign fdb_l   = LW'(first_data_block);
    assign idx_l   = LW'(idx_reg);
    assign start_l = (fdb_l > N_L) ? N_L : fdb_l;
    assign base_l  = LW'(addr_reg) << 6;
    assign diff_l  = start_l - base_l;
    assign grant_l = LW'({rd_addr_reg, pos_reg});
    assign start_word = WA_W'(first_data_block >> 6);

    // Pattern written by the clearing pass and by a format sweep.
    always_comb
    begin
        if (cmd.sweep_zero || (start_l <= base_l))
        begin
            fmt_word = '0;
        end
        else if (start_l >= base_l + LW'(64))
        begin
            fmt_word = '1;
        end
        else
        begin
            fmt_word = (64'd1 << diff_l[5:0]) - 64'd1;
        end
    end

    // Reserved bits of the first scanned word and bits past the last block
    // are treated as taken.
    assign lo_mask  = (rd_addr_reg == start_word) ?
                      ((64'd1 << first_data_block[5:0]) - 64'd1) : 64'd0;
    assign hi_mask  = (rd_addr_reg == LAST_A) ? HI_MASK : 64'd0;
    assign free_vec = ~rd_data_reg & ~lo_mask & ~hi_mask;
    assign onehot   = free_vec & (~free_vec + 64'd1);

    always_comb
    begin
        pos = '0;
        for (int b = 0; b < 64; b++)
        begin
            if (onehot[b])
            begin
                pos = pos | 6'(b);
            end
        end
    end

    always_comb
    begin
        wr_en   = cmd.sweep_wr | cmd.commit_alloc | cmd.commit_free;
        wr_addr = addr_reg;
        wr_data = fmt_word;
        if (cmd.commit_alloc)
        begin
            wr_addr = rd_addr_reg;
            wr_data = rd_data_reg | oh_reg;
        end
        else if (cmd.commit_free)
        begin
            wr_addr = rd_addr_reg;
            wr_data = rd_data_reg & ~(64'd1 << idx_reg[5:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[addr_reg];
            rd_addr_reg <= addr_reg;
        end
        oh_reg  <= onehot;
        pos_reg <= pos;
        if (cmd.op_start)
        begin
            op_reg  <= opcode;
            idx_reg <= block_index;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_grant_reg  <= cmd.commit_alloc ? grant_l[11:0] : 12'd0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_grant_reg  <= res_grant_reg;
            out_free_reg   <= 13'(LW'(free_total_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            scan_end_reg   <= 1'b0;
            free_total_reg <= CNT_W'(NUM_BLOCKS);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd;
            if (cmd.op_start)
            begin
                scan_end_reg <= 1'b0;
                if (opcode == OP_ALLOC)
                begin
                    addr_reg <= start_word;
                end
                else if (opcode == OP_FREE)
                begin
                    addr_reg <= WA_W'(block_index >> 6);
                end
                else
                begin
                    addr_reg <= '0;
                end
            end
            else if (cmd.sweep_wr || cmd.rd)
            begin
                addr_reg <= addr_reg + WA_W'(1);
                if (cmd.rd && (addr_reg == LAST_A))
                begin
                    scan_end_reg <= 1'b1;
                end
            end

            if (cmd.count_load)
            begin
                free_total_reg <= CNT_W'(N_L - start_l);
            end
            else if (cmd.commit_alloc)
            begin
                free_total_reg <= free_total_reg - CNT_W'(1);
            end
            else if (cmd.commit_free && (LW'(free_total_reg) < N_L))
            begin
                free_total_reg <= free_total_reg + CNT_W'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.opcode     = op_reg;
    assign stat.last_addr  = (addr_reg == LAST_A);
    assign stat.count_zero = (free_total_reg == '0);
    assign stat.start_bad  = (fdb_l >= N_L);
    assign stat.idx_bad    = (idx_l < fdb_l) || (idx_l >= N_L);
    assign stat.rd_vld     = rd_vld_reg;
    assign stat.hit        = |free_vec;
    assign stat.rd_last    = (rd_addr_reg == LAST_A);
    assign stat.scan_end   = scan_end_reg;
    assign stat.bit_used   = rd_data_reg[idx_reg[5:0]];
    assign stat.out_busy   = out_valid_reg && out_stall;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_block = out_grant_reg;
    assign blocks_free   = out_free_reg;

endmodule
